>>> hw/rtl/link_reconnect_backoff_monitor_defines.svh
// Assertion macros shared by the link reconnect backoff monitor RTL.
`ifndef LINK_RECONNECT_BACKOFF_MONITOR_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_MONITOR_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define LRBM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LRBM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LRBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lrbm_pkg.sv
// Types and constants of the link reconnect backoff monitor.
`timescale 1ns / 1ps

package lrbm_pkg;

  localparam int unsigned REG_W  = 27;
  localparam int unsigned TIME_W = 32;

  localparam logic [REG_W-1:0] CHECK_INTERVAL_RESET = 27'd5000;
  localparam logic [REG_W-1:0] RETRY_MIN_RESET      = 27'd5000;
  localparam logic [REG_W-1:0] RETRY_MAX_RESET      = 27'd300000;

  typedef enum logic [1:0] {
    REG_CHECK_INTERVAL = 2'd0,
    REG_RETRY_MIN      = 2'd1,
    REG_RETRY_MAX      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
    logic              has_credentials;
    logic              clear_stats;
  } poll_t;

  typedef struct packed {
    logic              checked;
    logic              reconnect_now;
    logic              link_gained;
    logic              link_lost;
    logic [REG_W-1:0]  retry_delay_ms;
    logic [TIME_W-1:0] disconnects;
    logic [TIME_W-1:0] uptime_ms;
    logic [TIME_W-1:0] downtime_ms;
    logic [TIME_W-1:0] last_loss_ms;
    logic [TIME_W-1:0] last_gain_ms;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0] check_interval_ms;
    logic [REG_W-1:0] retry_min_ms;
    logic [REG_W-1:0] retry_max_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_check_time;
    logic [REG_W-1:0]  backoff_delay;
    logic              prev_link_up;
    logic [TIME_W-1:0] last_attempt_time;
    logic [TIME_W-1:0] up_span_start;
    logic              up_span_valid;
    logic [TIME_W-1:0] down_span_start;
    logic              down_span_valid;
    logic [TIME_W-1:0] uptime_total;
    logic [TIME_W-1:0] downtime_total;
    logic [TIME_W-1:0] loss_count;
    logic [TIME_W-1:0] loss_stamp;
    logic [TIME_W-1:0] gain_stamp;
  } state_t;

endpackage

>>> hw/rtl/lrbm_stream_if.sv
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps

interface lrbm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/lrbm_cfg_regs.sv
// APB-style configuration registers of the link reconnect backoff monitor.
`timescale 1ns / 1ps

module lrbm_cfg_regs
  import lrbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval_ms <= CHECK_INTERVAL_RESET;
      cfg.retry_min_ms      <= RETRY_MIN_RESET;
      cfg.retry_max_ms      <= RETRY_MAX_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_CHECK_INTERVAL: cfg.check_interval_ms <= pwdata[REG_W-1:0];
        REG_RETRY_MIN:      cfg.retry_min_ms      <= pwdata[REG_W-1:0];
        REG_RETRY_MAX:      cfg.retry_max_ms      <= pwdata[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHECK_INTERVAL: prdata = {5'd0, cfg.check_interval_ms};
      REG_RETRY_MIN:      prdata = {5'd0, cfg.retry_min_ms};
      REG_RETRY_MAX:      prdata = {5'd0, cfg.retry_max_ms};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/lrbm_poll_logic.sv
// Single-pass evaluation of one poll against the monitor state.
`timescale 1ns / 1ps

module lrbm_poll_logic
  import lrbm_pkg::*;
(
  input  poll_t   item,
  input  state_t  st,
  input  cfg_t    cfg,
  output state_t  st_next,
  output result_t res
);

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] base_up;
  logic [TIME_W-1:0] base_down;
  logic [TIME_W-1:0] base_loss;
  logic [TIME_W-1:0] base_loss_stamp;
  logic [TIME_W-1:0] base_gain_stamp;
  logic              chk;
  logic              gained;
  logic              lost;
  logic              reconnect;
  logic [REG_W:0]    doubled;
  logic [REG_W-1:0]  backoff_sat;
  logic [TIME_W-1:0] up_add;
  logic [TIME_W-1:0] down_add;

  assign now = item.now_ms;

  always_comb begin
    base_up         = item.clear_stats ? '0 : st.uptime_total;
    base_down       = item.clear_stats ? '0 : st.downtime_total;
    base_loss       = item.clear_stats ? '0 : st.loss_count;
    base_loss_stamp = item.clear_stats ? '0 : st.loss_stamp;
    base_gain_stamp = item.clear_stats ? '0 : st.gain_stamp;

    chk    = (now - st.last_check_time) >= {5'd0, cfg.check_interval_ms};
    gained = chk && item.link_up && !st.prev_link_up;
    lost   = chk && !item.link_up && st.prev_link_up;

    // A gain forces the link up, so the reconnect test can use the stored delay.
    reconnect = chk && !item.link_up && item.has_credentials &&
                ((now - st.last_attempt_time) >= {5'd0, st.backoff_delay});
    doubled     = {st.backoff_delay, 1'b0};
    backoff_sat = (doubled < {1'b0, cfg.retry_max_ms}) ? doubled[REG_W-1:0]
                                                       : cfg.retry_max_ms;

    st_next                   = st;
    st_next.last_check_time   = chk ? now : st.last_check_time;
    st_next.prev_link_up      = chk ? item.link_up : st.prev_link_up;
    st_next.last_attempt_time = reconnect ? now : st.last_attempt_time;
    st_next.backoff_delay     = gained    ? cfg.retry_min_ms :
                                reconnect ? backoff_sat : st.backoff_delay;

    st_next.downtime_total = base_down +
                             ((gained && st.down_span_valid) ? now - st.down_span_start : '0);
    st_next.uptime_total   = base_up +
                             ((lost && st.up_span_valid) ? now - st.up_span_start : '0);
    st_next.loss_count     = base_loss + {31'd0, lost};
    st_next.loss_stamp     = lost ? now : base_loss_stamp;
    st_next.gain_stamp     = gained ? now : base_gain_stamp;

    st_next.up_span_valid   = gained ? 1'b1 : (lost ? 1'b0 : st.up_span_valid);
    st_next.up_span_start   = gained ? now : st.up_span_start;
    st_next.down_span_valid = lost ? 1'b1 : (gained ? 1'b0 : st.down_span_valid);
    st_next.down_span_start = lost ? now : st.down_span_start;

    up_add   = (st_next.prev_link_up && st_next.up_span_valid) ?
               now - st_next.up_span_start : '0;
    down_add = (!st_next.prev_link_up && st_next.down_span_valid) ?
               now - st_next.down_span_start : '0;

    res.checked        = chk;
    res.reconnect_now  = reconnect;
    res.link_gained    = gained;
    res.link_lost      = lost;
    res.retry_delay_ms = st_next.backoff_delay;
    res.disconnects    = st_next.loss_count;
    res.uptime_ms      = st_next.uptime_total + up_add;
    res.downtime_ms    = st_next.downtime_total + down_add;
    res.last_loss_ms   = st_next.loss_stamp;
    res.last_gain_ms   = st_next.gain_stamp;
  end

endmodule

>>> hw/rtl/link_reconnect_backoff_monitor.sv
// Link monitor that tracks up and down time and paces reconnects with exponential backoff.
//
// Each poll transfer carries a timestamp and the link, credentials and clear flags; each poll
// produces one result transfer with the event flags and the live statistics. The block takes
// one poll per clock cycle while the result is not stalled: the poll is held in an input register,
// evaluated in one pass of compare, add and shift logic against the running state registers,
// and the result is held in an output register. A stalled result holds off the next poll
// once the input register is full. Configuration is written through the APB port at byte
// addresses 0 (check interval), 4 (minimum retry delay) and 8 (maximum retry delay) and
// should only be changed while no polls are in flight.
`timescale 1ns / 1ps
`include "link_reconnect_backoff_monitor_defines.svh"

module link_reconnect_backoff_monitor
  import lrbm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lrbm_stream_if.sink   poll,
  lrbm_stream_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t res_c;
  poll_t   p1;
  result_t r2;
  logic    v1;
  logic    v2;
  logic    adv;
  logic    take;
  logic    move;

  lrbm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrbm_poll_logic u_poll_logic (
    .item    (p1),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res_c)
  );

  assign adv          = !v2 || result.ready;
  assign poll.ready   = !v1 || adv;
  assign take         = poll.valid && poll.ready;
  assign move         = v1 && adv;
  assign result.valid = v2;
  assign result.data  = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      st <= '{last_check_time:   '0,
              backoff_delay:     RETRY_MIN_RESET,
              prev_link_up:      1'b0,
              last_attempt_time: '0,
              up_span_start:     '0,
              up_span_valid:     1'b0,
              down_span_start:   '0,
              down_span_valid:   1'b0,
              uptime_total:      '0,
              downtime_total:    '0,
              loss_count:        '0,
              loss_stamp:        '0,
              gain_stamp:        '0};
    end else begin
      if (poll.ready) begin
        v1 <= poll.valid;
      end
      if (adv) begin
        v2 <= v1;
      end
      if (move) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p1 <= poll.data;
    end
    if (move) begin
      r2 <= res_c;
    end
  end

  `LRBM_ASSERT_ALWAYS(a_one_open_span, clk, rst, !(st.up_span_valid && st.down_span_valid), "both spans open")
  `LRBM_ASSERT_IMPLY(a_up_span_link, clk, rst, st.up_span_valid, st.prev_link_up, "up span open while link down")
  `LRBM_ASSERT_NEXT(a_gain_sets_link, clk, rst, move && res_c.link_gained, st.prev_link_up && st.up_span_valid, "gain not recorded")
  `LRBM_ASSERT_NEXT(a_stalled_poll_held, clk, rst, v1 && !adv, v1, "held poll dropped")

endmodule
